// File: src/ssc_pkg.sv
// Shared types and constants for the segment stabbing counter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ssc_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int COORD_W      = 32;
   localparam int MODE_W       = 2;
   localparam int HIT_W        = 7;
   localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

   typedef enum logic [MODE_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef struct packed {
      logic                      valid;
      op_type                    op;
      logic                      taken;
      logic signed [COORD_W-1:0] seg_start;
      logic signed [COORD_W-1:0] seg_end;
      logic signed [COORD_W-1:0] point;
      logic [HIT_W-1:0]          hits;
   } token_type;

endpackage

// File: src/ssc_cell.sv
// One segment cell of the chain: holds one segment and its occupancy bit.
// Passes the token to the next cell each enabled cycle; uses ssc_pkg.
`timescale 1ns / 1ps

module ssc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  ssc_pkg::token_type  tok_in,
   output ssc_pkg::token_type  tok_out
);

   logic                               occ_ff;
   logic                               occ_in;
   logic signed [ssc_pkg::COORD_W-1:0] start_ff;
   logic signed [ssc_pkg::COORD_W-1:0] end_ff;
   logic                               capture;
   logic                               match;
   ssc_pkg::token_type                 tok_ff;
   ssc_pkg::token_type                 tok_in_next;

   always_comb begin
      capture     = 1'b0;
      match       = 1'b0;
      occ_in      = occ_ff;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         unique case (tok_in.op)
            ssc_pkg::OP_CLEAR: begin
               occ_in = 1'b0;
            end
            ssc_pkg::OP_LOAD: begin
               if (!tok_in.taken && !occ_ff) begin
                  capture           = 1'b1;
                  occ_in            = 1'b1;
                  tok_in_next.taken = 1'b1;
               end
            end
            ssc_pkg::OP_QUERY: begin
               match = occ_ff && (start_ff <= tok_in.point) && (tok_in.point <= end_ff);
            end
            default: begin
               occ_in = occ_ff;
            end
         endcase
      end
      // saturate the running count
      if (match && (tok_in.hits != ssc_pkg::HIT_MAX)) begin
         tok_in_next.hits = tok_in.hits + ssc_pkg::HIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (en) begin
         occ_ff <= occ_in;
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (en && capture) begin
         start_ff <= tok_in.seg_start;
         end_ff   <= tok_in.seg_end;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: src/ssc_out_stage.sv
// Chain exit: sticky drop flag, result register and the global advance enable.
// Takes the token from the last cell; uses ssc_pkg.
`timescale 1ns / 1ps

module ssc_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  ssc_pkg::token_type         tok,
   output logic                       advance,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [ssc_pkg::HIT_W-1:0]  hit_count,
   output logic                       load_dropped
);

   logic                      rsp_valid_ff;
   logic                      drop_ff;
   logic                      drop_in;
   logic [ssc_pkg::HIT_W-1:0] hit_ff;
   logic                      dropped_ff;

   assign advance = !rsp_valid_ff || rsp_tready;

   always_comb begin
      drop_in = drop_ff;
      if (tok.valid) begin
         unique case (tok.op)
            ssc_pkg::OP_CLEAR: drop_in = 1'b0;
            ssc_pkg::OP_LOAD:  drop_in = drop_ff || !tok.taken;
            default:           drop_in = drop_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         drop_ff      <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tok.valid && (tok.op == ssc_pkg::OP_QUERY);
         drop_ff      <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff     <= tok.hits;
         dropped_ff <= drop_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign hit_count    = hit_ff;
   assign load_dropped = dropped_ff;

endmodule

// File: src/segment_stabbing_counter_core.sv
// A request passes through each cell register in chain order, then the result register.
// Throughput: one item per cycle unless a result is stalled; a stalled result halts the whole cell chain.
// Reset clears every cell's occupancy bit, the chain valids and the drop flag;
// segment storage is not cleared and needs no sweep.
// Top level of the segment stabbing counter; uses ssc_pkg, ssc_cell, ssc_out_stage.
`timescale 1ns / 1ps

module segment_stabbing_counter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // seg_start[31:0], seg_end[63:32], point_value[95:64]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // hit_count[6:0], load_dropped[7]
);

   localparam int N = ssc_pkg::MAX_SEGMENTS;

   ssc_pkg::token_type        tok [N+1];
   logic                      advance;
   logic [ssc_pkg::HIT_W-1:0] hit_count;
   logic                      load_dropped;

   assign req_tready = advance;

   always_comb begin
      tok[0].valid = req_tvalid && ((req_tuser == ssc_pkg::OP_CLEAR)
                                 || (req_tuser == ssc_pkg::OP_LOAD)
                                 || (req_tuser == ssc_pkg::OP_QUERY));
      tok[0].op        = ssc_pkg::op_type'(req_tuser);
      tok[0].taken     = 1'b0;
      tok[0].seg_start = req_tdata[31:0];
      tok[0].seg_end   = req_tdata[63:32];
      tok[0].point     = req_tdata[95:64];
      tok[0].hits      = '0;
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      ssc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (advance),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   ssc_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .tok          (tok[N]),
      .advance      (advance),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .hit_count    (hit_count),
      .load_dropped (load_dropped)
   );

   assign rsp_tdata = {load_dropped, hit_count};

endmodule

// File: src/ssc_checker.sv
// Port-level checks for the segment stabbing counter and their bind.
// Sees only the top-level ports; uses ssc_pkg.
`timescale 1ns / 1ps

module ssc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [95:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown({req_tuser, req_tdata}))
      else $error("request transfer carries unknown bits");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not track result slot");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[6:0]) <= ssc_pkg::MAX_SEGMENTS))
      else $error("hit count exceeds table size");

endmodule

bind segment_stabbing_counter_core ssc_checker u_ssc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
